// ===== rtl/md5h_pkg.sv =====
package md5h_pkg;

  typedef logic [3:0][31:0] word4_t;

  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [31:0] data;
  } buf_wr_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] sine_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hD76AA478; 6'd1:  k = 32'hE8C7B756; 6'd2:  k = 32'h242070DB;
      6'd3:  k = 32'hC1BDCEEE; 6'd4:  k = 32'hF57C0FAF; 6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613; 6'd7:  k = 32'hFD469501; 6'd8:  k = 32'h698098D8;
      6'd9:  k = 32'h8B44F7AF; 6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193; 6'd14: k = 32'hA679438E;
      6'd15: k = 32'h49B40821; 6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA; 6'd20: k = 32'hD62F105D;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6; 6'd26: k = 32'hF4D50D87;
      6'd27: k = 32'h455A14ED; 6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A; 6'd32: k = 32'hFFFA3942;
      6'd33: k = 32'h8771F681; 6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9; 6'd38: k = 32'hF6BB4B60;
      6'd39: k = 32'hBEBFBC70; 6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05; 6'd44: k = 32'hD9D4D039;
      6'd45: k = 32'hE6DB99E5; 6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97; 6'd50: k = 32'hAB9423A7;
      6'd51: k = 32'hFC93A039; 6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1; 6'd56: k = 32'h6FA87E4F;
      6'd57: k = 32'hFE2CE6E0; 6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235; 6'd62: k = 32'h2AD7D2BB;
      default: k = 32'hEB86D391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] shift_amt(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] x;
    logic [3:0] g;
    x = r[3:0];
    case (r[5:4])
      2'd0:    g = x;
      2'd1:    g = 4'((x << 2) + x + 4'd1);
      2'd2:    g = 4'((x << 1) + x + 4'd5);
      default: g = 4'((x << 3) - x);
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/md5h_comp.sv =====
module md5h_comp
  import md5h_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  buf_wr_t buf_wr,
  input  logic    start,
  input  word4_t  chain,
  output logic    done,
  output word4_t  work
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_LOAD = 2'd1;
  localparam logic [1:0] C_RUN  = 2'd2;
  localparam logic [1:0] C_FIN  = 2'd3;

  logic [31:0] buf_mem [16];
  logic [31:0] rdata_r;
  logic [3:0]  rd_addr;
  logic [1:0]  st_r, st_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  word4_t      work_r, work_nxt;
  logic [31:0] a, b, c, d, f, t;
  logic [63:0] rot;

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      buf_mem[buf_wr.addr] <= buf_wr.data;
    end
    rdata_r <= buf_mem[rd_addr];
  end

  always_comb begin
    a = work_r[0];
    b = work_r[1];
    c = work_r[2];
    d = work_r[3];
    case (rnd_r[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    t = a + f + sine_k(rnd_r) + rdata_r;
    rot = {t, t} << shift_amt(rnd_r);
  end

  always_comb begin
    st_nxt   = st_r;
    rnd_nxt  = rnd_r;
    work_nxt = work_r;
    rd_addr  = msg_index(6'(rnd_r + 6'd1));
    case (st_r)
      C_IDLE: begin
        if (start) begin
          st_nxt   = C_LOAD;
          rnd_nxt  = '0;
          work_nxt = chain;
        end
      end
      C_LOAD: begin
        rd_addr = msg_index(rnd_r);
        st_nxt  = C_RUN;
      end
      C_RUN: begin
        work_nxt = {c, b, b + rot[63:32], d};
        rnd_nxt  = 6'(rnd_r + 6'd1);
        if (rnd_r == 6'd63) begin
          st_nxt = C_FIN;
        end
      end
      default: begin
        st_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= C_IDLE;
      rnd_r <= '0;
    end else begin
      st_r  <= st_nxt;
      rnd_r <= rnd_nxt;
    end
    work_r <= work_nxt;
  end

  assign done = (st_r == C_FIN);
  assign work = work_r;

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    buf_wr.en |-> (st_r == C_IDLE || st_r == C_FIN))
    else $error("buffer written during compression");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> st_r == C_IDLE)
    else $error("start while busy");
  a_fin_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(st_r) == C_RUN && $past(rnd_r) == 6'd63)
    else $error("done without last round");

endmodule

// ===== rtl/md5_stream_hasher.sv =====
// MD5 hasher over a byte stream.
// Input channel: in_valid/in_stall with in_msg_byte, in_has_byte and
// in_end_of_message. One byte is taken per accepted word; a word with
// in_has_byte low and in_end_of_message high closes the message without a
// byte. A word with both low changes nothing.
// Output channel: out_valid/out_stall with out_digest_half and
// out_is_final_half. Each message gives two words: digest bytes 0-7, then
// bytes 8-15, lowest byte in bits 7:0.
// Throughput: one byte per cycle while filling a block; each full 64-byte
// block then holds the input for a load step, 64 rounds through the
// single round unit reading the block memory, and one chain add.
// Closing a message pads byte by byte and runs one or two more
// compressions before the first digest word appears.
// Reset clears the chain to the MD5 initial vector, the length and the fill
// position; the block is then ready for a new message at once. The block
// memory needs no clearing. A stall on the output holds the digest word and
// keeps the input stalled; after the second digest word is taken the block
// returns to its reset state.
module md5_stream_hasher
  import md5h_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_half,
  output logic        out_is_final_half
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_OUT0 = 3'd3;
  localparam logic [2:0] S_OUT1 = 3'd4;

  logic [2:0]  st_r, st_nxt;
  word4_t      chain_r, chain_nxt;
  logic [63:0] len_r, len_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] word_r, word_nxt;
  logic        fin_r, fin_nxt;
  logic        sent_r, sent_nxt;
  logic        lenph_r, lenph_nxt;
  logic        last_r, last_nxt;
  logic [63:0] lo_r, lo_nxt, hi_r, hi_nxt;

  logic        in_acc, out_acc;
  logic        put_en;
  logic [7:0]  put_val;
  logic        lenph_now;
  logic        start;
  logic        done;
  word4_t      work;
  word4_t      sum;
  buf_wr_t     buf_wr;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (st_r != S_IDLE);

  assign lenph_now = lenph_r || (sent_r && pos_r == LEN_POS);

  always_comb begin
    sum[0] = chain_r[0] + work[0];
    sum[1] = chain_r[1] + work[1];
    sum[2] = chain_r[2] + work[2];
    sum[3] = chain_r[3] + work[3];
  end

  always_comb begin
    put_en  = 1'b0;
    put_val = in_msg_byte;
    if (st_r == S_IDLE) begin
      put_en = in_acc && in_has_byte;
    end else if (st_r == S_PAD) begin
      put_en = 1'b1;
      if (!sent_r) begin
        put_val = PAD_BYTE;
      end else if (lenph_now) begin
        put_val = len_r[{pos_r[2:0], 3'b000} +: 8];
      end else begin
        put_val = '0;
      end
    end
  end

  always_comb begin
    word_nxt = word_r;
    word_nxt[{pos_r[1:0], 3'b000} +: 8] = put_val;
  end

  assign buf_wr.en   = put_en && (pos_r[1:0] == 2'd3);
  assign buf_wr.addr = pos_r[5:2];
  assign buf_wr.data = word_nxt;
  assign start       = put_en && (pos_r == 6'd63);

  always_comb begin
    st_nxt    = st_r;
    chain_nxt = chain_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    fin_nxt   = fin_r;
    sent_nxt  = sent_r;
    lenph_nxt = lenph_r;
    last_nxt  = last_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    if (put_en) begin
      pos_nxt = 6'(pos_r + 6'd1);
    end
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_has_byte) begin
            len_nxt = 64'(len_r + 64'd8);
          end
          fin_nxt = in_end_of_message;
          if (start) begin
            st_nxt = S_CMP;
          end else if (in_end_of_message) begin
            st_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        sent_nxt  = 1'b1;
        lenph_nxt = sent_r && lenph_now;
        if (start) begin
          last_nxt = sent_r && lenph_now;
          st_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        if (done) begin
          chain_nxt = sum;
          if (last_r) begin
            lo_nxt = {sum[1], sum[0]};
            hi_nxt = {sum[3], sum[2]};
            st_nxt = S_OUT0;
          end else if (fin_r) begin
            st_nxt = S_PAD;
          end else begin
            st_nxt = S_IDLE;
          end
        end
      end
      S_OUT0: begin
        if (out_acc) begin
          st_nxt = S_OUT1;
        end
      end
      S_OUT1: begin
        if (out_acc) begin
          st_nxt    = S_IDLE;
          chain_nxt = {IV_D, IV_C, IV_B, IV_A};
          len_nxt   = '0;
          pos_nxt   = '0;
          fin_nxt   = 1'b0;
          sent_nxt  = 1'b0;
          lenph_nxt = 1'b0;
          last_nxt  = 1'b0;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      chain_r <= {IV_D, IV_C, IV_B, IV_A};
      len_r   <= '0;
      pos_r   <= '0;
      fin_r   <= 1'b0;
      sent_r  <= 1'b0;
      lenph_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      chain_r <= chain_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      fin_r   <= fin_nxt;
      sent_r  <= sent_nxt;
      lenph_r <= lenph_nxt;
      last_r  <= last_nxt;
    end
    word_r <= word_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
  end

  md5h_comp u_comp (
    .clk    (clk),
    .rst_n  (rst_n),
    .buf_wr (buf_wr),
    .start  (start),
    .chain  (chain_r),
    .done   (done),
    .work   (work)
  );

  assign out_valid         = (st_r == S_OUT0) || (st_r == S_OUT1);
  assign out_is_final_half = (st_r == S_OUT1);
  assign out_digest_half   = (st_r == S_OUT1) ? hi_r : lo_r;

  a_done_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> st_r == S_CMP)
    else $error("compression finished outside wait state");
  a_out_block_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pos_r == 6'd0 && last_r)
    else $error("digest shown with partial block");
  a_start_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> st_r == S_CMP)
    else $error("compression started without wait");

endmodule

// ===== tb/sv/md5_stream_hasher_tb.sv =====
`timescale 1ns / 100ps

module md5_stream_hasher_tb;

  typedef struct {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       eom;
  } msg_word_t;

  typedef struct {
    logic [63:0] half;
    logic        is_final;
  } digest_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_msg_byte;
  logic        in_has_byte;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_digest_half;
  logic        out_is_final_half;

  md5_stream_hasher uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_msg_byte(in_msg_byte), .in_has_byte(in_has_byte),
    .in_end_of_message(in_end_of_message),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_half(out_digest_half), .out_is_final_half(out_is_final_half)
  );

  msg_word_t    pending_words[$];
  digest_word_t expected_digests[$];

  logic [31:0] chain[4];
  logic [31:0] blk[16];
  logic [63:0] msg_bits;
  int          fill;

  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_off_cycles;
  bit  drain_pause;
  bit  failed;
  int  quiet_cycles;

  localparam int QUIET_LIMIT = 20000;

  localparam logic [31:0] SINE_K[64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE, 32'hF57C0FAF, 32'h4787C62A,
    32'hA8304613, 32'hFD469501, 32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821, 32'hF61E2562, 32'hC040B340,
    32'h265E5A51, 32'hE9B6C7AA, 32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED, 32'hA9E3E905, 32'hFCEFA3F8,
    32'h676F02D9, 32'h8D2A4C8A, 32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70, 32'h289B7EC6, 32'hEAA127FA,
    32'hD4EF3085, 32'h04881D05, 32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039, 32'h655B59C3, 32'h8F0CCC92,
    32'hFFEFF47D, 32'h85845DD1, 32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };
  localparam int ROT_AMT[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  function automatic logic [31:0] rotl(logic [31:0] v, int s);
    return (s == 0) ? v : ((v << s) | (v >> (32 - s)));
  endfunction

  task automatic restart_chain();
    chain[0] = 32'h67452301;
    chain[1] = 32'hEFCDAB89;
    chain[2] = 32'h98BADCFE;
    chain[3] = 32'h10325476;
    msg_bits = '0;
    fill = 0;
  endtask

  task automatic compress();
    logic [31:0] a, b, c, d, f, t;
    int g, ph;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int r = 0; r < 64; r++) begin
      ph = r / 16;
      case (ph)
        0: begin f = (b & c) | (~b & d); g = r; end
        1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * r + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
      endcase
      t = a + f + SINE_K[r] + blk[g];
      t = b + rotl(t, ROT_AMT[ph * 4 + r % 4]);
      a = d; d = c; c = b; b = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic absorb_byte(logic [7:0] v);
    blk[fill / 4][(fill % 4) * 8 +: 8] = v;
    fill = (fill + 1) % 64;
    if (fill == 0) compress();
  endtask

  task automatic predict_digest(msg_word_t w);
    logic [63:0] len;
    digest_word_t dw;
    if (w.has_byte) begin
      msg_bits += 64'd8;
      absorb_byte(w.msg_byte);
    end
    if (w.eom) begin
      len = msg_bits;
      absorb_byte(8'h80);
      while (fill != 56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len[8 * i +: 8]);
      dw.half = {chain[1], chain[0]}; dw.is_final = 1'b0;
      expected_digests.insert(expected_digests.size(), dw);
      dw.half = {chain[3], chain[2]}; dw.is_final = 1'b1;
      expected_digests.insert(expected_digests.size(), dw);
      restart_chain();
    end
  endtask

  task automatic queue_word(logic [7:0] b, logic hb, logic e);
    msg_word_t w;
    w.msg_byte = b; w.has_byte = hb; w.eom = e;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic queue_message(int len, bit close_with_byte);
    for (int i = 0; i < len; i++)
      queue_word(8'($urandom), 1'b1, close_with_byte && (i == len - 1));
    if (!close_with_byte || len == 0) queue_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_digests.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  task automatic random_phase(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_word(8'($urandom), 1'b0, 1'b0);
      end else begin
        case ($urandom_range(0, 5))
          0: len = $urandom_range(0, 3);
          1: len = $urandom_range(54, 58);
          2: len = $urandom_range(62, 66);
          3: len = $urandom_range(119, 130);
          default: len = $urandom_range(4, 50);
        endcase
        queue_message(len, $urandom_range(0, 1));
        sent += len + 1;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      in_valid <= 1'b1;
    end else if (!drain_pause && pending_words.size() != 0 &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      in_valid          <= 1'b1;
      in_msg_byte       <= pending_words[0].msg_byte;
      in_has_byte       <= pending_words[0].has_byte;
      in_end_of_message <= pending_words[0].eom;
      void'(pending_words.pop_front());
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      msg_word_t w;
      w.msg_byte = in_msg_byte; w.has_byte = in_has_byte; w.eom = in_end_of_message;
      predict_digest(w);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_digests.size() == 0) begin
        $error("unexpected digest word %h", out_digest_half);
        failed <= 1'b1;
      end else begin
        if (out_digest_half !== expected_digests[0].half) begin
          $error("digest_half: expected %h actual %h",
                 expected_digests[0].half, out_digest_half);
          failed <= 1'b1;
        end
        if (out_is_final_half !== expected_digests[0].is_final) begin
          $error("is_final_half: expected %b actual %b",
                 expected_digests[0].is_final, out_is_final_half);
          failed <= 1'b1;
        end
        void'(expected_digests.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_msg_byte = '0; in_has_byte = 1'b0;
    in_end_of_message = 1'b0; out_stall = 1'b0;
    send_idle_pct = 6; recv_idle_pct = 46; hold_off_cycles = 0;
    drain_pause = 1'b0; failed = 1'b0; quiet_cycles = 0;
    for (int i = 0; i < 16; i++) blk[i] = '0;
    restart_chain();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    queue_word(8'h00, 1'b0, 1'b1);
    queue_word(8'hFF, 1'b0, 1'b0);
    queue_word(8'h00, 1'b1, 1'b1);
    queue_word(8'hFF, 1'b1, 1'b1);
    queue_word(8'h61, 1'b1, 1'b0);
    queue_word(8'h62, 1'b1, 1'b0);
    queue_word(8'h63, 1'b1, 1'b0);
    queue_word(8'hA5, 1'b0, 1'b1);
    for (int i = 0; i < 55; i++) queue_word(8'($urandom), 1'b1, i == 54);
    for (int i = 0; i < 56; i++) queue_word(8'($urandom), 1'b1, 1'b0);
    queue_word(8'h00, 1'b0, 1'b1);
    for (int i = 0; i < 64; i++) queue_word(8'($urandom), 1'b1, i == 63);
    wait_drained();

    // hold the output until the input backs up
    hold_off_cycles <= 600;
    queue_message(130, 1'b1);
    queue_message(20, 1'b0);
    wait_drained();

    random_phase(190);
    wait_drained();
    drain_pause <= 1'b1;
    repeat (20) @(posedge clk);
    drain_pause <= 1'b0;

    send_idle_pct = 46; recv_idle_pct = 6;
    random_phase(190);
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(190);
    wait_drained();
    repeat (300) @(posedge clk);
    if (!failed && expected_digests.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== md5_stream_hasher.f =====
rtl/md5h_pkg.sv
rtl/md5h_comp.sv
rtl/md5_stream_hasher.sv
tb/sv/md5_stream_hasher_tb.sv
